@@ rtl/m14cv_pkg.sv @@
// ----------------------------------------------------------------------------
// m14cv_pkg
// Shared types, constants and tables for the 14-bit CC to CV converter.
// ----------------------------------------------------------------------------
package m14cv_pkg;

   // Field widths
   localparam int LEVEL_W     = 21;   // signed Q5.16 volts
   localparam int DATA_W      = 7;    // MIDI data byte
   localparam int STATUS_W    = 8;
   localparam int CHAN_SEL_W  = 5;
   localparam int PCT_W       = 7;
   localparam int CODE_W      = 14;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 7;

   // Item kinds
   localparam logic KIND_MESSAGE = 1'b0;
   localparam logic KIND_TICK    = 1'b1;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_CC_SELECT      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHANNEL_SELECT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BIPOLAR_MODE   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SMOOTHING      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPLACE_MODE   = 3'd4;

   // MIDI codes
   localparam logic [3:0]        CC_STATUS_NIBBLE = 4'hB;
   localparam logic [DATA_W-1:0] CC_ALL_RESET     = 7'd121;
   localparam logic [DATA_W-1:0] CC_ALL_NOTES_OFF = 7'd123;
   localparam int                LSB_OFFSET       = 32;
   localparam logic [DATA_W-1:0] CC_SELECT_RESET  = 7'd1;

   // Scaling
   localparam int CODE_MAX   = 16383;
   localparam int HALF_SCALE = 327680;      // 5 V in Q5.16
   localparam int LEVEL_MAX  = 1048575;
   localparam int LEVEL_MIN  = -1048576;

   // Smoothing coefficient: ceil(num * 2^COEF_SHIFT / COEF_DEN)
   localparam int COEF_W      = 36;
   localparam int COEF_SHIFT  = 35;
   localparam int COEF_DEN    = 10000;
   localparam int SMOOTH_STEP = 99;
   localparam int SMOOTH_MAX  = 100;

   typedef logic [COEF_W-1:0] coef_table_type [0:SMOOTH_MAX];

   typedef struct packed {
      logic [DATA_W-1:0]     cc_select;
      logic [CHAN_SEL_W-1:0] channel_select;
      logic                  bipolar_mode;
      logic                  replace_mode;
      logic [COEF_W-1:0]     coef;
   } cfg_type;

   typedef struct packed {
      logic clear_fire;     // accepted clear message this cycle
      logic target_write;   // target level reloaded this cycle
   } msg_status_type;

   function automatic coef_table_type build_coef_table();
      coef_table_type t;
      logic [63:0]    num;
      for (int p = 0; p <= SMOOTH_MAX; p++) begin
         num  = 64'(COEF_DEN - SMOOTH_STEP * p);
         t[p] = COEF_W'(((num << COEF_SHIFT) + 64'(COEF_DEN - 1)) / 64'(COEF_DEN));
      end
      return t;
   endfunction

   localparam coef_table_type COEF_TABLE = build_coef_table();

   // Saturate a 23-bit signed sum to the Q5.16 range
   function automatic logic signed [LEVEL_W-1:0] sat_level(input logic signed [22:0] v);
      logic signed [LEVEL_W-1:0] r;
      if (v > 23'(LEVEL_MAX)) begin
         r = LEVEL_W'(LEVEL_MAX);
      end else if (v < 23'(LEVEL_MIN)) begin
         r = LEVEL_W'(LEVEL_MIN);
      end else begin
         r = v[LEVEL_W-1:0];
      end
      return r;
   endfunction

endpackage

@@ rtl/m14cv_csr.sv @@
// ----------------------------------------------------------------------------
// m14cv_csr
// Configuration registers; smoothing percent is stored as its coefficient.
// ----------------------------------------------------------------------------
module m14cv_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write,
   input  logic [m14cv_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [m14cv_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output m14cv_pkg::cfg_type                    cfg
);
   import m14cv_pkg::*;

   cfg_type          cfg_ff;
   cfg_type          cfg_in;
   logic [PCT_W-1:0] pct_clamped;

   always_comb begin
      cfg_in      = cfg_ff;
      pct_clamped = (csr_wdata > PCT_W'(SMOOTH_MAX)) ? PCT_W'(SMOOTH_MAX) : csr_wdata;
      if (csr_write) begin
         unique case (csr_index)
            CSR_CC_SELECT:      cfg_in.cc_select      = csr_wdata;
            CSR_CHANNEL_SELECT: cfg_in.channel_select = csr_wdata[CHAN_SEL_W-1:0];
            CSR_BIPOLAR_MODE:   cfg_in.bipolar_mode   = csr_wdata[0];
            CSR_SMOOTHING:      cfg_in.coef           = COEF_TABLE[pct_clamped];
            CSR_REPLACE_MODE:   cfg_in.replace_mode   = csr_wdata[0];
            default:            cfg_in                = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cc_select      <= CC_SELECT_RESET;
         cfg_ff.channel_select <= '0;
         cfg_ff.bipolar_mode   <= 1'b0;
         cfg_ff.replace_mode   <= 1'b0;
         cfg_ff.coef           <= COEF_TABLE[0];
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/m14cv_msg.sv @@
// ----------------------------------------------------------------------------
// m14cv_msg
// Control change decode, held MSB/LSB and target level.
// ----------------------------------------------------------------------------
module m14cv_msg (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     msg_fire,
   input  logic [m14cv_pkg::STATUS_W-1:0]           status_byte,
   input  logic [m14cv_pkg::DATA_W-1:0]             data_first,
   input  logic [m14cv_pkg::DATA_W-1:0]             data_second,
   input  m14cv_pkg::cfg_type                       cfg,
   output logic signed [m14cv_pkg::LEVEL_W-1:0]     target_level,
   output m14cv_pkg::msg_status_type                msg_status
);
   import m14cv_pkg::*;

   logic [DATA_W-1:0]         msb_held_ff, msb_held_in;
   logic [DATA_W-1:0]         lsb_held_ff, lsb_held_in;
   logic                      msb_seen_ff, msb_seen_in;
   logic                      lsb_seen_ff, lsb_seen_in;
   logic signed [LEVEL_W-1:0] target_ff, target_in;

   logic              is_cc, chan_ok, hit, clear_hit, msb_hit, lsb_hit, reload;
   logic [CODE_W-1:0] code;
   logic [17:0]       code_x10;
   logic [33:0]       scaled;
   logic [19:0]       q0, q1, quot;
   logic [20:0]       r0;
   logic [6:0]        r0_hi;
   logic [14:0]       r1;
   logic signed [LEVEL_W-1:0] level;

   // Decode and state update
   always_comb begin
      is_cc     = (status_byte[7:4] == CC_STATUS_NIBBLE);
      chan_ok   = (cfg.channel_select == '0)
               || ((5'(status_byte[3:0]) + 5'd1) == cfg.channel_select);
      hit       = msg_fire && is_cc && chan_ok;
      clear_hit = (data_first == CC_ALL_RESET)
               || ((data_first == CC_ALL_NOTES_OFF) && (data_second == '0));
      msb_hit   = (data_first == cfg.cc_select);
      lsb_hit   = !msb_hit
               && ({1'b0, data_first} == ({1'b0, cfg.cc_select} + 8'(LSB_OFFSET)));

      msb_held_in = msb_held_ff;
      lsb_held_in = lsb_held_ff;
      msb_seen_in = msb_seen_ff;
      lsb_seen_in = lsb_seen_ff;
      reload      = 1'b0;
      if (hit) begin
         if (clear_hit) begin
            msb_held_in = '0;
            lsb_held_in = '0;
            msb_seen_in = 1'b0;
            lsb_seen_in = 1'b0;
         end else begin
            if (msb_hit) begin
               msb_held_in = data_second;
               msb_seen_in = 1'b1;
            end else if (lsb_hit) begin
               lsb_held_in = data_second;
               lsb_seen_in = 1'b1;
            end
            reload = msb_seen_in || lsb_seen_in;
         end
      end
   end

   // Level = round(code * 655360 / 16383); divide by 2^14-1 via folding
   always_comb begin
      if (msb_seen_in && lsb_seen_in) begin
         code = {msb_held_in, lsb_held_in};
      end else if (msb_seen_in) begin
         code = {msb_held_in, 7'd0};
      end else begin
         code = {7'd0, lsb_held_in};
      end
      code_x10 = 18'({code, 3'd0}) + 18'({code, 1'b0});
      scaled   = {code_x10, 16'd0} + 34'(CODE_MAX / 2);
      q0       = scaled[33:14];
      r0       = 21'(scaled[13:0]) + 21'(q0);
      r0_hi    = r0[20:14];
      q1       = q0 + 20'(r0_hi);
      r1       = 15'(r0[13:0]) + 15'(r0_hi);
      quot     = (r1 >= 15'(CODE_MAX)) ? q1 + 20'd1 : q1;
      level    = $signed({1'b0, quot})
               - (cfg.bipolar_mode ? LEVEL_W'(HALF_SCALE) : LEVEL_W'(0));
      target_in = target_ff;
      if (hit && clear_hit) begin
         target_in = '0;
      end else if (reload) begin
         target_in = level;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         msb_held_ff <= '0;
         lsb_held_ff <= '0;
         msb_seen_ff <= 1'b0;
         lsb_seen_ff <= 1'b0;
         target_ff   <= '0;
      end else begin
         msb_held_ff <= msb_held_in;
         lsb_held_ff <= lsb_held_in;
         msb_seen_ff <= msb_seen_in;
         lsb_seen_ff <= lsb_seen_in;
         target_ff   <= target_in;
      end
   end

   assign target_level            = target_ff;
   assign msg_status.clear_fire   = hit && clear_hit;
   assign msg_status.target_write = reload;

endmodule

@@ rtl/m14cv_tick.sv @@
// ----------------------------------------------------------------------------
// m14cv_tick
// One smoothing step per tick and, unless in replace mode, the bus add with saturation.
// ----------------------------------------------------------------------------
module m14cv_tick (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     tick_fire,
   input  logic                                     clear_fire,
   input  logic signed [m14cv_pkg::LEVEL_W-1:0]     target_level,
   input  logic signed [m14cv_pkg::LEVEL_W-1:0]     bus_sample,
   input  m14cv_pkg::cfg_type                       cfg,
   output logic signed [m14cv_pkg::LEVEL_W-1:0]     cv_sample
);
   import m14cv_pkg::*;

   logic signed [LEVEL_W-1:0] smoothed_ff, smoothed_in;
   logic signed [LEVEL_W:0]   delta;
   logic [LEVEL_W:0]          mag;
   logic [57:0]               prod;
   logic [57:0]               rounded;
   logic [LEVEL_W:0]          step_mag;
   logic signed [22:0]        step;
   logic signed [22:0]        moved;
   logic signed [LEVEL_W-1:0] level_new;
   logic signed [22:0]        with_bus;

   always_comb begin
      delta    = $signed({target_level[LEVEL_W-1], target_level})
               - $signed({smoothed_ff[LEVEL_W-1], smoothed_ff});
      mag      = delta[LEVEL_W] ? 22'(-delta) : 22'(delta);
      prod     = 58'(mag) * 58'(cfg.coef);
      rounded  = prod + (58'd1 << (COEF_SHIFT - 1));
      step_mag = rounded[COEF_SHIFT + LEVEL_W:COEF_SHIFT];
      step     = delta[LEVEL_W] ? -$signed({1'b0, step_mag}) : $signed({1'b0, step_mag});
      moved    = $signed({{2{smoothed_ff[LEVEL_W-1]}}, smoothed_ff}) + step;
      level_new = sat_level(moved);
      with_bus = $signed({{2{level_new[LEVEL_W-1]}}, level_new})
               + $signed({{2{bus_sample[LEVEL_W-1]}}, bus_sample});
      cv_sample = cfg.replace_mode ? level_new : sat_level(with_bus);

      smoothed_in = smoothed_ff;
      if (clear_fire) begin
         smoothed_in = '0;
      end else if (tick_fire) begin
         smoothed_in = level_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         smoothed_ff <= '0;
      end else begin
         smoothed_ff <= smoothed_in;
      end
   end

endmodule

@@ rtl/midi_14bit_cc_to_cv.sv @@
// ----------------------------------------------------------------------------
// midi_14bit_cc_to_cv
// 14-bit MIDI control change pair to smoothed control voltage (Q5.16).
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake              Payload
//  req_*    in         req_valid/req_ready    kind, status byte, data bytes,
//                                             bus sample (Q5.16)
//  rsp_*    out        rsp_valid/rsp_ready    cv_sample (Q5.16), one per tick
//  csr_*    in         csr_valid/csr_ready    csr_index, csr_wdata
//
//  One request per cycle, sustained while no tick is held by a waiting
//  result. A request is captured in the input register, then one pass of
//  logic updates the held state and, for a tick, loads the result register.
//  The smoothing loop (subtract, 22x36 multiply, add, saturate) sets the
//  clock path; it closes on the smoothed level register each cycle.
//  A waiting result stalls a tick, and the requests behind it; messages drain past it.
//  Synchronous active-high reset clears all but payload registers and loads register defaults.
//
module midi_14bit_cc_to_cv (
   input  logic                                     clock,
   input  logic                                     reset,
   // request channel
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic                                     req_kind,
   input  logic [m14cv_pkg::STATUS_W-1:0]           req_status_byte,
   input  logic [m14cv_pkg::DATA_W-1:0]             req_data_first,
   input  logic [m14cv_pkg::DATA_W-1:0]             req_data_second,
   input  logic signed [m14cv_pkg::LEVEL_W-1:0]     req_bus_sample,
   // result channel
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic signed [m14cv_pkg::LEVEL_W-1:0]     rsp_cv_sample,
   // configuration
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [m14cv_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [m14cv_pkg::CSR_DATA_W-1:0]         csr_wdata
);
   import m14cv_pkg::*;

   // input register
   logic                      in_valid_ff, in_valid_in;
   logic                      in_kind_ff;
   logic [STATUS_W-1:0]       in_status_ff;
   logic [DATA_W-1:0]         in_first_ff;
   logic [DATA_W-1:0]         in_second_ff;
   logic signed [LEVEL_W-1:0] in_bus_ff;

   // result register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [LEVEL_W-1:0] rsp_cv_ff, rsp_cv_in;

   logic                      req_fire, in_fire, tick_fire, msg_fire, slot_free;
   cfg_type                   cfg;
   msg_status_type            msg_status;
   logic signed [LEVEL_W-1:0] target_level;
   logic signed [LEVEL_W-1:0] cv_sample;

   // Messages never produce a result, so they drain regardless of rsp_ready
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign in_fire   = in_valid_ff && ((in_kind_ff == KIND_MESSAGE) || slot_free);
   assign tick_fire = in_fire && (in_kind_ff == KIND_TICK);
   assign msg_fire  = in_fire && (in_kind_ff == KIND_MESSAGE);
   assign req_ready = !in_valid_ff || in_fire;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   always_comb begin
      in_valid_in = req_fire ? 1'b1 : (in_fire ? 1'b0 : in_valid_ff);
      rsp_valid_in = tick_fire ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
      rsp_cv_in    = tick_fire ? cv_sample : rsp_cv_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_kind_ff   <= req_kind;
         in_status_ff <= req_status_byte;
         in_first_ff  <= req_data_first;
         in_second_ff <= req_data_second;
         in_bus_ff    <= req_bus_sample;
      end
      rsp_cv_ff <= rsp_cv_in;
   end

   m14cv_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   m14cv_msg u_msg (
      .clock        (clock),
      .reset        (reset),
      .msg_fire     (msg_fire),
      .status_byte  (in_status_ff),
      .data_first   (in_first_ff),
      .data_second  (in_second_ff),
      .cfg          (cfg),
      .target_level (target_level),
      .msg_status   (msg_status)
   );

   m14cv_tick u_tick (
      .clock        (clock),
      .reset        (reset),
      .tick_fire    (tick_fire),
      .clear_fire   (msg_status.clear_fire),
      .target_level (target_level),
      .bus_sample   (in_bus_ff),
      .cfg          (cfg),
      .cv_sample    (cv_sample)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_cv_sample = rsp_cv_ff;

`ifndef SYNTH
   // a tick in the input register always lands in the result register
   assert property (@(posedge clock) disable iff (reset) tick_fire |=> rsp_valid)
      else $error("tick did not produce a result");

   // a result only appears after a tick left the input register
   assert property (@(posedge clock) disable iff (reset) $rose(rsp_valid) |-> $past(tick_fire))
      else $error("result without tick");

   // clear drops the target to zero
   assert property (@(posedge clock) disable iff (reset)
      msg_status.clear_fire |=> (target_level == '0))
      else $error("clear did not zero target");

   // a blocked tick holds off new requests
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && (in_kind_ff == KIND_TICK) && !slot_free) |-> !req_ready)
      else $error("request taken over a stalled tick");

   // messages and ticks never fire together
   assert property (@(posedge clock) disable iff (reset) $onehot0({tick_fire, msg_fire}))
      else $error("message and tick fired together");
`endif

endmodule

@@ verif/tb_midi_14bit_cc_to_cv.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_midi_14bit_cc_to_cv
// Self-checking bench for the 14-bit CC to CV converter. A queue-fed driver
// pushes MIDI and tick requests, and a bit-true model of the CC pairing,
// target scaling and smoothing predicts each tick's cv_sample. A monitor
// compares every returned sample against the oldest prediction. The run
// steps through register settings, including the extremes, under several
// backpressure patterns.
// ----------------------------------------------------------------------------
module tb_midi_14bit_cc_to_cv;
   import m14cv_pkg::*;

   localparam int     PHASES         = 10;
   localparam int     PHASE_ITEMS    = 158;
   localparam int     QUIET_CYCLES   = 4;          // a tick goes through the input and result registers
   localparam int     REPORT_LIMIT   = 10;
   localparam longint RUN_LIMIT_NS   = 4_000_000;  // far above a clean run
   localparam int     FULL_SCALE_Q16 = 2 * HALF_SCALE;

   // Status bytes that are not control change
   localparam logic [STATUS_W-1:0] STATUS_NOTE_ON   = 8'h90;
   localparam logic [STATUS_W-1:0] STATUS_POLY_AT   = 8'hAF;
   localparam logic [STATUS_W-1:0] STATUS_PROGRAM   = 8'hC0;
   localparam logic [STATUS_W-1:0] STATUS_SYS_RESET = 8'hFF;
   localparam logic [STATUS_W-1:0] STATUS_NULL      = 8'h00;

   localparam logic [DATA_W-1:0] LSB_DEFAULT = DATA_W'(CC_SELECT_RESET + LSB_OFFSET);

   typedef struct {
      logic                      kind;
      logic [STATUS_W-1:0]       status;
      logic [DATA_W-1:0]         num;
      logic [DATA_W-1:0]         val;
      logic signed [LEVEL_W-1:0] bus;
   } midi_req_type;

   // ------------------------------------------------------------------------
   // Clock, reset and DUT ports; every input starts at a known value
   // ------------------------------------------------------------------------
   logic                      clock           = 1'b0;
   logic                      reset           = 1'b1;
   logic                      req_valid       = 1'b0;
   logic                      req_ready;
   logic                      req_kind        = KIND_MESSAGE;
   logic [STATUS_W-1:0]       req_status_byte = '0;
   logic [DATA_W-1:0]         req_data_first  = '0;
   logic [DATA_W-1:0]         req_data_second = '0;
   logic signed [LEVEL_W-1:0] req_bus_sample  = '0;
   logic                      rsp_valid;
   logic                      rsp_ready       = 1'b0;
   logic signed [LEVEL_W-1:0] rsp_cv_sample;
   logic                      csr_valid       = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_W-1:0]    csr_index       = '0;
   logic [CSR_DATA_W-1:0]     csr_wdata       = '0;

   always #10 clock = ~clock;

   midi_14bit_cc_to_cv DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_status_byte (req_status_byte),
      .req_data_first  (req_data_first),
      .req_data_second (req_data_second),
      .req_bus_sample  (req_bus_sample),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_cv_sample   (rsp_cv_sample),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   // ------------------------------------------------------------------------
   // Converter model: register copy plus held CC state
   // ------------------------------------------------------------------------
   logic [DATA_W-1:0]         sel_cc     = CC_SELECT_RESET;
   logic [CHAN_SEL_W-1:0]     sel_chan   = '0;
   logic                      bipolar_en = 1'b0;
   logic [PCT_W-1:0]          smooth_pct = '0;
   logic                      replace_en = 1'b0;

   logic [DATA_W-1:0]         held_msb   = '0;
   logic [DATA_W-1:0]         held_lsb   = '0;
   logic                      got_msb    = 1'b0;
   logic                      got_lsb    = 1'b0;
   logic signed [LEVEL_W-1:0] target_q16 = '0;
   logic signed [LEVEL_W-1:0] level_q16  = '0;

   midi_req_type              pending_reqs [$];   // requests not yet presented
   logic signed [LEVEL_W-1:0] cv_expected  [$];   // predicted samples, oldest first
   int                        error_count     = 0;
   int                        sender_idle_pct = 0;
   int                        sink_stall_pct  = 0;

   function automatic logic signed [LEVEL_W-1:0] clamp_q16(input longint v);
      if (v > LEVEL_MAX) return LEVEL_W'(LEVEL_MAX);
      if (v < LEVEL_MIN) return LEVEL_W'(LEVEL_MIN);
      return LEVEL_W'(v);
   endfunction

   // Advance the model by one accepted request. Ticks queue a sample;
   // messages only touch the held state.
   task automatic track_request(input midi_req_type r);
      longint            delta, mag, stepv, num, lvl;
      int                pct;
      logic [CODE_W-1:0] code;
      if (r.kind == KIND_TICK) begin
         pct   = (smooth_pct > SMOOTH_MAX) ? SMOOTH_MAX : int'(smooth_pct);
         num   = COEF_DEN - SMOOTH_STEP * pct;
         delta = longint'(target_q16) - longint'(level_q16);
         mag   = (delta < 0) ? -delta : delta;
         // rounded step, halves away from zero
         stepv = (mag * num + COEF_DEN / 2) / COEF_DEN;
         if (delta < 0) stepv = -stepv;
         level_q16 = clamp_q16(longint'(level_q16) + stepv);
         if (replace_en) begin
            cv_expected.push_back(level_q16);
         end else begin
            cv_expected.push_back(clamp_q16(longint'(level_q16) + longint'(r.bus)));
         end
      end else if (r.status[7:4] == CC_STATUS_NIBBLE &&
                   (sel_chan == 0 || int'(r.status[3:0]) == int'(sel_chan) - 1)) begin
         if (r.num == CC_ALL_RESET || (r.num == CC_ALL_NOTES_OFF && r.val == 0)) begin
            // all-reset, or all-notes-off with value 0: drop everything, 0 V at once
            held_msb   = '0;
            held_lsb   = '0;
            got_msb    = 1'b0;
            got_lsb    = 1'b0;
            target_q16 = '0;
            level_q16  = '0;
         end else begin
            if (r.num == sel_cc) begin
               held_msb = r.val;
               got_msb  = 1'b1;
            end else if (int'(r.num) == int'(sel_cc) + LSB_OFFSET) begin
               held_lsb = r.val;
               got_lsb  = 1'b1;
            end
            if (got_msb || got_lsb) begin
               if (got_msb && got_lsb) code = {held_msb, held_lsb};
               else if (got_msb)       code = {held_msb, 7'd0};
               else                    code = {7'd0, held_lsb};
               lvl = (longint'(code) * FULL_SCALE_Q16 + CODE_MAX / 2) / CODE_MAX;
               if (bipolar_en) lvl = lvl - HALF_SCALE;
               target_q16 = LEVEL_W'(lvl);
            end
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Request builders
   // ------------------------------------------------------------------------
   function automatic midi_req_type cc_msg(input logic [STATUS_W-1:0] status,
                                           input logic [DATA_W-1:0] num,
                                           input logic [DATA_W-1:0] val);
      midi_req_type r;
      r.kind   = KIND_MESSAGE;
      r.status = status;
      r.num    = num;
      r.val    = val;
      r.bus    = LEVEL_W'($urandom);
      return r;
   endfunction

   function automatic midi_req_type tick_req(input logic signed [LEVEL_W-1:0] bus);
      midi_req_type r;
      r.kind   = KIND_TICK;
      r.status = STATUS_W'($urandom);
      r.num    = DATA_W'($urandom);
      r.val    = DATA_W'($urandom);
      r.bus    = bus;
      return r;
   endfunction

   // Mostly ticks and CC pairs aimed at the selected controller and channel,
   // with clears, stray controllers and non-CC traffic mixed in.
   function automatic midi_req_type random_req();
      midi_req_type r;
      int unsigned  pick;
      logic [3:0]   chan;
      pick     = $urandom_range(99);
      r.kind   = KIND_MESSAGE;
      r.status = STATUS_W'($urandom);
      r.num    = DATA_W'($urandom);
      if ($urandom_range(7) == 0) r.val = $urandom_range(1) ? '1 : '0;
      else                        r.val = DATA_W'($urandom);
      // small bus swings now and then so add mode does not always saturate
      if ($urandom_range(3) == 0) r.bus = LEVEL_W'($signed(18'($urandom)));
      else                        r.bus = LEVEL_W'($urandom);
      if (sel_chan != 0 && sel_chan <= 16 && $urandom_range(9) != 0) begin
         chan = 4'(sel_chan - 1);
      end else begin
         chan = 4'($urandom);
      end
      if (pick < 55) begin
         r.kind = KIND_TICK;
      end else if (pick < 90) begin
         r.status = {CC_STATUS_NIBBLE, chan};
         r.num    = $urandom_range(1) ? sel_cc : DATA_W'(sel_cc + LSB_OFFSET);
      end else if (pick < 93) begin
         r.status = {CC_STATUS_NIBBLE, chan};
         r.num    = $urandom_range(1) ? CC_ALL_RESET : CC_ALL_NOTES_OFF;
         if ($urandom_range(1)) r.val = '0;
      end else if (pick < 97) begin
         r.status = {CC_STATUS_NIBBLE, chan};   // some other controller
      end
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Register writes: only issued while the converter is quiet, so the
   // model copy is updated at the write itself.
   // ------------------------------------------------------------------------
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_CC_SELECT:      sel_cc     = data;
         CSR_CHANNEL_SELECT: sel_chan   = data[CHAN_SEL_W-1:0];
         CSR_BIPOLAR_MODE:   bipolar_en = data[0];
         CSR_SMOOTHING:      smooth_pct = data;
         CSR_REPLACE_MODE:   replace_en = data[0];
         default: ;          // spare indexes hold nothing
      endcase
   endtask

   task automatic load_setting(input int cc, input int chan, input int bip,
                               input int pct, input int repl);
      write_csr(CSR_CC_SELECT,      CSR_DATA_W'(cc));
      write_csr(CSR_CHANNEL_SELECT, CSR_DATA_W'(chan));
      write_csr(CSR_BIPOLAR_MODE,   CSR_DATA_W'(bip));
      write_csr(CSR_SMOOTHING,      CSR_DATA_W'(pct));
      write_csr(CSR_REPLACE_MODE,   CSR_DATA_W'(repl));
   endtask

   // Wait for every request to go in and every sample to come back, then let
   // a trailing message that may still be in the pipe drain.
   task automatic wait_quiet();
      while (pending_reqs.size() != 0 || req_valid || cv_expected.size() != 0) begin
         @(posedge clock);
      end
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Request driver: records the accepted request in the model, then either
   // presents the next one or goes idle. Valid is never dropped while waiting.
   // ------------------------------------------------------------------------
   midi_req_type req_cur;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            track_request(req_cur);
         end
         if (!req_valid || req_ready) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               req_cur = pending_reqs.pop_front();
               req_valid       <= 1'b1;
               req_kind        <= req_cur.kind;
               req_status_byte <= req_cur.status;
               req_data_first  <= req_cur.num;
               req_data_second <= req_cur.val;
               req_bus_sample  <= req_cur.bus;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Sample monitor: random backpressure, in-order compare
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : cv_monitor
      logic signed [LEVEL_W-1:0] want;
      rsp_ready <= ($urandom_range(99) >= sink_stall_pct);
      if (!reset && rsp_valid && rsp_ready) begin
         if (cv_expected.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_LIMIT) begin
               $display("cv_sample %0d returned with nothing outstanding", rsp_cv_sample);
            end
         end else begin
            want = cv_expected.pop_front();
            if (rsp_cv_sample !== want) begin
               error_count++;
               if (error_count <= REPORT_LIMIT) begin
                  $display("cv_sample mismatch: expected %0d, got %0d", want, rsp_cv_sample);
               end
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------------
   initial begin : test_sequence
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // spare register indexes must not disturb anything
      for (int i = CSR_REPLACE_MODE + 1; i < 2 ** CSR_INDEX_W; i++) begin
         write_csr(CSR_INDEX_W'(i), CSR_DATA_W'($urandom));
      end

      // Directed pass at reset settings: CC 1/33, any channel, 0..10 V,
      // no smoothing, add mode.
      pending_reqs.push_back(tick_req('0));                          // 0 V out of reset
      pending_reqs.push_back(cc_msg({CC_STATUS_NIBBLE, 4'h0}, CC_SELECT_RESET, 7'd127));
      pending_reqs.push_back(tick_req('0));                          // MSB alone
      pending_reqs.push_back(cc_msg({CC_STATUS_NIBBLE, 4'hF}, LSB_DEFAULT, 7'd127));
      pending_reqs.push_back(tick_req(LEVEL_W'(LEVEL_MAX)));         // full scale, sum clips high
      pending_reqs.push_back(tick_req(LEVEL_W'(LEVEL_MIN)));
      pending_reqs.push_back(cc_msg(STATUS_NOTE_ON, CC_SELECT_RESET, 7'd0));  // not CC
      pending_reqs.push_back(cc_msg(STATUS_POLY_AT, CC_SELECT_RESET, 7'd0));
      pending_reqs.push_back(cc_msg(STATUS_PROGRAM, LSB_DEFAULT, 7'd0));
      pending_reqs.push_back(tick_req('0));
      pending_reqs.push_back(cc_msg({CC_STATUS_NIBBLE, 4'h5}, CC_ALL_NOTES_OFF, 7'd5));
      pending_reqs.push_back(tick_req(LEVEL_W'(-1)));                // nonzero value: no clear
      pending_reqs.push_back(cc_msg({CC_STATUS_NIBBLE, 4'h3}, CC_ALL_NOTES_OFF, 7'd0));
      pending_reqs.push_back(tick_req(LEVEL_W'(-1)));
      pending_reqs.push_back(cc_msg({CC_STATUS_NIBBLE, 4'h0}, LSB_DEFAULT, 7'd1));
      pending_reqs.push_back(tick_req('0));                          // LSB alone
      pending_reqs.push_back(cc_msg({CC_STATUS_NIBBLE, 4'h9}, CC_ALL_RESET, 7'd127));
      pending_reqs.push_back(tick_req(LEVEL_W'(LEVEL_MAX)));
      pending_reqs.push_back(cc_msg({CC_STATUS_NIBBLE, 4'h0}, CC_SELECT_RESET, 7'd0));
      pending_reqs.push_back(tick_req(LEVEL_W'(LEVEL_MIN)));         // sum lands on the low limit
      pending_reqs.push_back(cc_msg(STATUS_SYS_RESET, 7'd127, 7'd127));
      pending_reqs.push_back(cc_msg(STATUS_NULL, 7'd0, 7'd0));
      pending_reqs.push_back(tick_req('0));
      wait_quiet();

      // Random phases. Settings cover CC 0/127, LSB numbers past 127,
      // a CC that collides with all-reset, channels 0/16 and the dead ones
      // above 16, smoothing 0/100 and the clamped range above it.
      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: load_setting(1, 0, 1, 0, 1);
            1: load_setting(0, 1, 0, 50, 0);
            2: load_setting(127, 16, 1, 100, 1);
            3: load_setting(95, 10, 0, 127, 1);
            4: load_setting(96, 0, 1, 1, 0);
            5: load_setting(64, 17, 0, 99, 1);
            6: load_setting(121, 0, 0, 10, 1);
            7: load_setting(7, 31, 1, 30, 0);
            default: load_setting($urandom_range(127), $urandom_range(127),
                                  $urandom_range(127), $urandom_range(127),
                                  $urandom_range(127));
         endcase
         case (ph % 4)
            0: begin sender_idle_pct = 0;  sink_stall_pct = 0;  end
            1: begin sender_idle_pct = 69; sink_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  sink_stall_pct = 69; end
            default: begin sender_idle_pct = 22; sink_stall_pct = 22; end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            pending_reqs.push_back(random_req());
         end
         wait_quiet();
      end

      if (error_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Hang guard
   initial begin : run_limit
      #(RUN_LIMIT_NS);
      $display("end of test: mismatches");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/m14cv_pkg.sv
rtl/m14cv_csr.sv
rtl/m14cv_msg.sv
rtl/m14cv_tick.sv
rtl/midi_14bit_cc_to_cv.sv
verif/tb_midi_14bit_cc_to_cv.sv
